### rtl/core/dltq_pkg.sv
// Shared types and codes for the delta-list timer queue.
package dltq_pkg;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_UNUSED   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RSVD  = 2'd3
  } status_t;

  // One queue slot; delta counts ticks from the slot ahead of it.
  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] delta;
    logic [15:0] period;
    logic [7:0]  runs;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

endpackage

### rtl/core/dltq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/delta_list_task_timer_queue_unit.sv
// Top level of the delta-list timer queue: sequencer around one entry RAM.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  input   | in_valid  | in_stall  | command, task_id, delay, period
//  output  | out_valid | out_stall | fired, fired_task, status
//
// One beat in gives one beat out. The sequencer owns the single RAM port
// pair, so in_stall stays high from acceptance until the result is loaded
// into the output register. Every RAM access is a read step then a
// write/compare step. A tick writes back the head as read while idle; on an
// empty queue, for a full add and for the unused code only the result is
// loaded. An add scans entries until its position is found, shifts the
// rest back by one slot and writes the new entry. Dispatch of a ready
// head moves the others forward, plus an add for a periodic task.
// Synchronous active-high rst clears the entry count and the control
// state; RAM contents are left alone and never used above the count.
// A held-off output stalls the sequencer in its last step only.
module delta_list_task_timer_queue_unit #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  task_id,
  input  logic [15:0] delay,
  input  logic [15:0] period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fired,
  output logic [7:0]  fired_task,
  output logic [1:0]  status
);

  localparam int unsigned AW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TICK   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_DR_RD  = 4'd3;
  localparam logic [3:0] S_DR_WR  = 4'd4;
  localparam logic [3:0] S_DR_END = 4'd5;
  localparam logic [3:0] S_INS    = 4'd6;
  localparam logic [3:0] S_SC_RD  = 4'd7;
  localparam logic [3:0] S_SC_CMP = 4'd8;
  localparam logic [3:0] S_SH_RD  = 4'd9;
  localparam logic [3:0] S_SH_WR  = 4'd10;
  localparam logic [3:0] S_WR_NEW = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;        // insert position being scanned
  logic [CW-1:0] idx;        // move index for remove / shift
  logic [15:0]   ahead_sum;  // summed delay of the entries ahead of pos
  logic [16:0]   at_reg;     // summed delay up to and including pos
  logic          periodic;

  // entry being inserted (new task or re-queued head)
  logic [7:0]    ins_task;
  logic [15:0]   ins_delay;
  logic [15:0]   ins_period;
  logic [7:0]    ins_runs;

  // result being built for the current beat
  logic          res_fired;
  logic [7:0]    res_task;
  logic [1:0]    res_status;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  dltq_pkg::entry_t rd_entry;
  dltq_pkg::entry_t wr_entry;
  logic [dltq_pkg::EntryWidth-1:0] ram_rdata;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] pos_inc;
  logic [16:0]   at_sum;
  logic          fits;
  logic [16:0]   split_diff;

  assign rd_entry   = dltq_pkg::entry_t'(ram_rdata);
  assign idx_inc    = idx + CW'(1);
  assign idx_dec    = idx - CW'(1);
  assign pos_inc    = pos + CW'(1);
  assign at_sum     = {1'b0, ahead_sum} + {1'b0, rd_entry.delta};
  assign fits       = ({1'b0, ins_delay} <= at_sum);
  assign split_diff = at_reg - {1'b0, ins_delay};
  assign in_stall   = (state != S_IDLE);

  dltq_ram #(
    .WIDTH (dltq_pkg::EntryWidth),
    .DEPTH (MAX_TASKS)
  ) u_entries (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // RAM port control; idle reads the head so tick and dispatch find it ready
  always_comb begin
    rd_addr  = '0;
    wr_addr  = '0;
    wr_en    = 1'b0;
    wr_entry = rd_entry;
    unique case (state)
      S_SC_RD: rd_addr = pos[AW-1:0];
      S_DR_RD: rd_addr = idx_inc[AW-1:0];
      S_SH_RD: rd_addr = idx_dec[AW-1:0];
      S_TICK: begin
        wr_en = 1'b1;
        if (rd_entry.delta != 16'd0) begin
          wr_entry.delta = rd_entry.delta - 16'd1;
        end else begin
          if (rd_entry.runs != 8'hFF) wr_entry.runs = rd_entry.runs + 8'd1;
          if (rd_entry.period != 16'd0) wr_entry.delta = rd_entry.period;
        end
      end
      S_DR_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        // entry displaced from the insert point keeps only the remainder
        if (idx == pos_inc) wr_entry.delta = split_diff[15:0];
      end
      S_WR_NEW: begin
        wr_en            = 1'b1;
        wr_addr          = pos[AW-1:0];
        wr_entry.task_id = ins_task;
        wr_entry.delta   = ins_delay - ahead_sum;
        wr_entry.period  = ins_period;
        wr_entry.runs    = ins_runs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // in the last step the output register is either kept or reloaded
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_fired  <= 1'b0;
            res_task   <= 8'd0;
            res_status <= dltq_pkg::STAT_OK;
            case (command)
              dltq_pkg::CMD_TICK: begin
                state <= (count == '0) ? S_FIN : S_TICK;
              end
              dltq_pkg::CMD_ADD: begin
                ins_task   <= task_id;
                ins_delay  <= delay;
                ins_period <= period;
                ins_runs   <= 8'd0;
                if (count == CW'(MAX_TASKS)) begin
                  res_status <= dltq_pkg::STAT_FULL;
                  state      <= S_FIN;
                end else begin
                  state <= S_INS;
                end
              end
              dltq_pkg::CMD_DISPATCH: begin
                if (count == '0) begin
                  res_status <= dltq_pkg::STAT_EMPTY;
                  state      <= S_FIN;
                end else begin
                  state <= S_DISP;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_TICK: state <= S_FIN;
        S_DISP: begin
          if (rd_entry.runs == 8'd0) begin
            res_status <= dltq_pkg::STAT_EMPTY;
            state      <= S_FIN;
          end else begin
            res_fired  <= 1'b1;
            res_task   <= rd_entry.task_id;
            ins_task   <= rd_entry.task_id;
            ins_delay  <= rd_entry.delta;
            ins_period <= rd_entry.period;
            ins_runs   <= rd_entry.runs - 8'd1;
            periodic   <= (rd_entry.period != 16'd0);
            count      <= count - CW'(1);
            idx        <= '0;
            state      <= (count > CW'(1)) ? S_DR_RD : S_DR_END;
          end
        end
        S_DR_RD: state <= S_DR_WR;
        S_DR_WR: begin
          idx   <= idx_inc;
          state <= (idx_inc < count) ? S_DR_RD : S_DR_END;
        end
        S_DR_END: state <= periodic ? S_INS : S_FIN;
        S_INS: begin
          pos       <= '0;
          ahead_sum <= 16'd0;
          state     <= (count == '0) ? S_WR_NEW : S_SC_RD;
        end
        S_SC_RD: state <= S_SC_CMP;
        S_SC_CMP: begin
          if (fits) begin
            // ties land ahead of equal entries
            at_reg <= at_sum;
            idx    <= count;
            state  <= S_SH_RD;
          end else begin
            ahead_sum <= at_sum[15:0];
            pos       <= pos_inc;
            state     <= (pos_inc == count) ? S_WR_NEW : S_SC_RD;
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (idx == pos_inc) begin
            state <= S_WR_NEW;
          end else begin
            idx   <= idx_dec;
            state <= S_SH_RD;
          end
        end
        S_WR_NEW: begin
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            fired      <= res_fired;
            fired_task <= res_task;
            status     <= res_status;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/delta_list_task_timer_queue_unit_check.sv
// Channel monitor, timer-queue predictor and result compare for the delta-list timer queue.
module delta_list_task_timer_queue_unit_check #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  task_id,
  input  logic [15:0] delay,
  input  logic [15:0] period,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        fired,
  input  logic [7:0]  fired_task,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic               fired;
    logic [7:0]         tid;
    dltq_pkg::status_t  status;
  } fire_report_t;

  // predicted queue contents; slots at or above slot_count are don't-care
  dltq_pkg::entry_t slots [MAX_TASKS];
  int unsigned      slot_count = 0;
  fire_report_t     reports_due [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // place a task by cumulative delay; new task goes ahead of equal ones
  function automatic void sched_insert(input logic [7:0] tid, input logic [15:0] dly,
                                       input logic [15:0] per, input logic [7:0] runs);
    int unsigned pos;
    int unsigned ahead;
    int unsigned upto;
    int unsigned i;
    if (slot_count >= MAX_TASKS) return;
    pos   = 0;
    ahead = 0;
    upto  = 0;
    while (pos < slot_count) begin
      upto = ahead + slots[pos].delta;
      if (dly <= upto) break;
      ahead = upto;
      pos++;
    end
    if (pos < slot_count) begin
      for (i = slot_count; i > pos; i--) slots[i] = slots[i - 1];
      slots[pos + 1].delta = 16'(upto - dly);
    end
    slots[pos].task_id = tid;
    slots[pos].delta   = 16'(dly - ahead);
    slots[pos].period  = per;
    slots[pos].runs    = runs;
    slot_count++;
  endfunction

  // successors keep their deltas untouched
  function automatic void sched_drop_head();
    int unsigned i;
    if (slot_count == 0) return;
    for (i = 0; i + 1 < slot_count; i++) slots[i] = slots[i + 1];
    slot_count--;
  endfunction

  function automatic fire_report_t timer_apply(input dltq_pkg::command_t cmd,
                                               input logic [7:0] tid,
                                               input logic [15:0] dly,
                                               input logic [15:0] per);
    fire_report_t     rep;
    dltq_pkg::entry_t head;
    rep = '{fired: 1'b0, tid: 8'd0, status: dltq_pkg::STAT_OK};
    case (cmd)
      dltq_pkg::CMD_TICK: begin
        if (slot_count > 0) begin
          if (slots[0].delta != 16'd0) begin
            slots[0].delta = slots[0].delta - 16'd1;
          end else begin
            if (slots[0].runs != 8'hFF) slots[0].runs = slots[0].runs + 8'd1;
            if (slots[0].period != 16'd0) slots[0].delta = slots[0].period;
          end
        end
      end
      dltq_pkg::CMD_ADD: begin
        if (slot_count < MAX_TASKS) sched_insert(tid, dly, per, 8'd0);
        else rep.status = dltq_pkg::STAT_FULL;
      end
      dltq_pkg::CMD_DISPATCH: begin
        if (slot_count > 0 && slots[0].runs != 8'd0) begin
          head      = slots[0];
          rep.fired = 1'b1;
          rep.tid   = head.task_id;
          sched_drop_head();
          if (head.period != 16'd0)
            sched_insert(head.task_id, head.delta, head.period, head.runs - 8'd1);
        end else begin
          rep.status = dltq_pkg::STAT_EMPTY;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic note_fail(input string what, input fire_report_t want, input fire_report_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected fired=%0d task=%0d status=%0d, got fired=%0d task=%0d status=%0d",
               $realtime, what, want.fired, want.tid, want.status,
               got.fired, got.tid, got.status);
  endtask

  always @(posedge clk) begin
    fire_report_t got;
    fire_report_t want;
    fire_report_t due;
    if (rst) begin
      slot_count = 0;
      reports_due.delete();
      outstanding <= 0;
    end else begin
      // output side first: a result can never belong to a beat taken at this edge
      if (out_valid && !out_stall) begin
        got = '{fired: fired, tid: fired_task, status: dltq_pkg::status_t'(status)};
        if (reports_due.size() == 0) begin
          note_fail("result with nothing due", '0, got);
        end else begin
          want = reports_due.pop_front();
          if (got.fired !== want.fired || got.tid !== want.tid || got.status !== want.status)
            note_fail("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        due = timer_apply(dltq_pkg::command_t'(command), task_id, delay, period);
        reports_due = {reports_due, due};
      end
      outstanding <= reports_due.size();
    end
  end

endmodule

### bench/delta_list_task_timer_queue_unit_test.sv
// Stimulus and verdict for the delta-list timer queue, with the result checker alongside.
module delta_list_task_timer_queue_unit_test;

  localparam int unsigned MaxTasks = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = dltq_pkg::CMD_TICK;
  logic [7:0]  task_id = 8'd0;
  logic [15:0] delay = 16'd0;
  logic [15:0] period = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        fired;
  logic [7:0]  fired_task;
  logic [1:0]  status;

  int fail_count;
  int outstanding;

  // calm = no idling on either side (one long stretch of the random part)
  logic calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  delta_list_task_timer_queue_unit #(
    .MAX_TASKS(MaxTasks)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .task_id    (task_id),
    .delay      (delay),
    .period     (period),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .fired      (fired),
    .fired_task (fired_task),
    .status     (status)
  );

  delta_list_task_timer_queue_unit_check #(
    .MAX_TASKS(MaxTasks)
  ) watch (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .task_id     (task_id),
    .delay       (delay),
    .period      (period),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fired       (fired),
    .fired_task  (fired_task),
    .status      (status),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Output back-pressure: stall about 36% of cycles, none during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
  // in_stall is read right after the edge, so it is the value the edge saw.
  task automatic offer_beat(input dltq_pkg::command_t cmd, input logic [7:0] tid,
                            input logic [15:0] dly, input logic [15:0] per);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    task_id  <= tid;
    delay    <= dly;
    period   <= per;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hard stop in case the block hangs or drops results.
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int                 n;
    int                 pick;
    dltq_pkg::command_t cmd;
    logic [15:0]        dly;
    logic [15:0]        per;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // empty queue: dispatch finds nothing, tick does nothing
    offer_beat(dltq_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0);
    offer_beat(dltq_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
    // unused code with every field bit set: all-zero result
    offer_beat(dltq_pkg::CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);

    // one-shot at delay 0: every tick adds a run; run count must saturate at 255
    offer_beat(dltq_pkg::CMD_ADD, 8'hFF, 16'd0, 16'd0);
    repeat (260) offer_beat(dltq_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
    // fires once and is dropped despite runs left
    offer_beat(dltq_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0);

    // periodic with period 1: tick reloads delay, runs pile up to 2
    offer_beat(dltq_pkg::CMD_ADD, 8'h00, 16'd0, 16'd1);
    repeat (3) offer_beat(dltq_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
    // reinserted with one run left, so it fires twice, then has nothing ready
    repeat (3) offer_beat(dltq_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0);

    // fill the queue: ties, a zero delay, the largest delay and period
    offer_beat(dltq_pkg::CMD_ADD, 8'd1, 16'd5, 16'd0);
    offer_beat(dltq_pkg::CMD_ADD, 8'd2, 16'd5, 16'd0);
    offer_beat(dltq_pkg::CMD_ADD, 8'd3, 16'd3, 16'd0);
    offer_beat(dltq_pkg::CMD_ADD, 8'd4, 16'd0, 16'd0);
    offer_beat(dltq_pkg::CMD_ADD, 8'd5, 16'hFFFF, 16'd0);
    offer_beat(dltq_pkg::CMD_ADD, 8'd6, 16'd2, 16'hFFFF);
    for (n = 7; n < 16; n++) offer_beat(dltq_pkg::CMD_ADD, 8'(n), 16'(n % 4), 16'd0);
    // one too many: rejected as full
    offer_beat(dltq_pkg::CMD_ADD, 8'hAA, 16'd1, 16'd1);
    repeat (2) begin
      offer_beat(dltq_pkg::CMD_TICK, 8'd0, 16'd0, 16'd0);
      offer_beat(dltq_pkg::CMD_DISPATCH, 8'd0, 16'd0, 16'd0);
    end

    // ---- random part ----
    // Small delays keep heads reaching zero so dispatches really fire.
    // Large delays and periodic tasks stay rare: they occupy slots for good.
    for (n = 0; n < 460; n++) begin
      calm = (n >= 300 && n < 420);
      pick = $urandom_range(99);
      if (pick < 40) cmd = dltq_pkg::CMD_TICK;
      else if (pick < 70) cmd = dltq_pkg::CMD_ADD;
      else if (pick < 96) cmd = dltq_pkg::CMD_DISPATCH;
      else cmd = dltq_pkg::CMD_UNUSED;
      dly = ($urandom_range(63) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(6));
      per = 16'd0;
      if ($urandom_range(23) == 0)
        per = ($urandom_range(7) == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 8));
      offer_beat(cmd, 8'($urandom_range(255)), dly, per);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // let the last beat's expectation land, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/dltq_pkg.sv
rtl/core/dltq_ram.sv
rtl/core/delta_list_task_timer_queue_unit.sv
bench/delta_list_task_timer_queue_unit_check.sv
bench/delta_list_task_timer_queue_unit_test.sv
